>>> design/rlsp_pkg.sv
// Shared constants, types and state codes for the run-length row span painter.
`default_nettype none
package rlsp_pkg;

  localparam int ROW_COUNT = 512;
  localparam int ROW_WIDTH = 512;
  localparam int MAX_RUNS  = 8;
  localparam int X_GRID    = 8;

  localparam int COL_W    = 16;
  localparam int BUF_RUNS = 2 * MAX_RUNS + 2;
  localparam int RAW      = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int SW       = $clog2(ROW_WIDTH);
  localparam int XW       = $clog2(ROW_WIDTH + X_GRID + 1024);
  localparam int MW       = $clog2(MAX_RUNS);
  localparam int NW       = $clog2(MAX_RUNS + 1);
  localparam int BW       = $clog2(BUF_RUNS + 1);

  typedef struct packed {
    logic [NW-1:0]                 cnt;
    logic [MAX_RUNS-1:0][SW-1:0]   st;
    logic [MAX_RUNS-1:0][COL_W-1:0] co;
  } row_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_LEFT,
    ST_RIGHT,
    ST_MERGE,
    ST_CAP,
    ST_SCAN,
    ST_DEL,
    ST_DIFF,
    ST_WRITE
  } rlsp_state_t;

endpackage
`default_nettype wire

>>> design/rlsp_row_mem.sv
// Row memory: one word per display row, one write and one registered read port.
`default_nettype none
module rlsp_row_mem (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [rlsp_pkg::RAW-1:0] waddr,
  input  wire rlsp_pkg::row_word_t     wdata,
  input  wire logic              re,
  input  wire logic [rlsp_pkg::RAW-1:0] raddr,
  output rlsp_pkg::row_word_t          rdata
);
  import rlsp_pkg::*;

  row_word_t mem [ROW_COUNT];
  row_word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

>>> design/run_length_row_span_painter.sv
// Top level: span painter sequencer over the run-length row memory.
//
// Usage notes:
//  - Each display row is a list of at most MAX_RUNS colour runs held in one
//    memory word (run count, run starts, run colours). A word is painted by
//    read, rebuild in local registers, then write back when columns changed.
//  - Input: a word (in_row, in_x_first, in_x_last, in_colour) is taken at a
//    clock edge with start high and busy low. Only one word is in work.
//  - Output: exactly one result per input word, shown for one cycle with
//    out_valid high. The receiver cannot stall; results are never held.
//  - Rejected words (row out of range or empty clamped span) answer in the
//    cycle after acceptance and leave busy low.
//  - Other words: a read, a left pass, a right pass, a merge pass, a cap
//    check, per cap merge a width scan, a delete and a cap check, a diff
//    walk and a write when the row changed. Result and busy low come in the
//    cycle after the last step. The list walks take one entry per cycle.
//  - Reset (rst_n low, synchronous) starts a clearing pass that sets every
//    row to one run of colour 0; busy stays high.
`default_nettype none
module run_length_row_span_painter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [8:0]  in_row,
  input  wire logic [9:0]  in_x_first,
  input  wire logic [9:0]  in_x_last,
  input  wire logic [15:0] in_colour,
  output logic             out_valid,
  output logic             out_rejected,
  output logic             out_changed,
  output logic [8:0]       out_diff_first,
  output logic [8:0]       out_diff_last,
  output logic [3:0]       out_merges
);
  import rlsp_pkg::*;

  localparam logic [XW-1:0] WLIM = XW'(ROW_WIDTH);

  rlsp_state_t state_r, state_nxt;

  // memory port
  logic      mem_we, mem_re;
  logic [RAW-1:0] mem_waddr;
  row_word_t mem_wdata, mem_rdata;

  // clearing counter
  logic [RAW:0] clr_r, clr_nxt;

  // request
  logic [RAW-1:0]   row_r, row_nxt;
  logic [XW-1:0]    xa_r, xa_nxt, xb_r, xb_nxt;
  logic [COL_W-1:0] col_r, col_nxt;

  // old row
  logic [XW-1:0]    os_r [MAX_RUNS];
  logic [XW-1:0]    os_nxt [MAX_RUNS];
  logic [COL_W-1:0] oc_r [MAX_RUNS];
  logic [COL_W-1:0] oc_nxt [MAX_RUNS];
  logic [NW-1:0]    on_r, on_nxt;

  // new row buffer
  logic [XW-1:0]    bx_r [BUF_RUNS];
  logic [XW-1:0]    bx_nxt [BUF_RUNS];
  logic [COL_W-1:0] bc_r [BUF_RUNS];
  logic [COL_W-1:0] bc_nxt [BUF_RUNS];
  logic [BW-1:0]    bn_r, bn_nxt;

  // walk indexes
  logic [BW-1:0] i_r, i_nxt, j_r, j_nxt, best_r, best_nxt;
  logic [XW-1:0] bestw_r, bestw_nxt;
  logic [XW-1:0] x_r, x_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [NW-1:0] ia_r, ia_nxt;
  logic [BW-1:0] ib_r, ib_nxt;
  logic          found_r, found_nxt;
  logic [3:0]    merges_r, merges_nxt;

  // result
  logic       ov_r, ov_nxt, orej_r, orej_nxt, ochg_r, ochg_nxt;
  logic [8:0] ofirst_r, ofirst_nxt, olast_r, olast_nxt;
  logic [3:0] omrg_r, omrg_nxt;

  rlsp_row_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (in_row[RAW-1:0]),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r    <= row_nxt;
    xa_r     <= xa_nxt;
    xb_r     <= xb_nxt;
    col_r    <= col_nxt;
    os_r     <= os_nxt;
    oc_r     <= oc_nxt;
    on_r     <= on_nxt;
    bx_r     <= bx_nxt;
    bc_r     <= bc_nxt;
    bn_r     <= bn_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    best_r   <= best_nxt;
    bestw_r  <= bestw_nxt;
    x_r      <= x_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    ia_r     <= ia_nxt;
    ib_r     <= ib_nxt;
    found_r  <= found_nxt;
    merges_r <= merges_nxt;
    orej_r   <= orej_nxt;
    ochg_r   <= ochg_nxt;
    ofirst_r <= ofirst_nxt;
    olast_r  <= olast_nxt;
    omrg_r   <= omrg_nxt;
  end

  always_comb begin
    logic [XW-1:0] xl, xf, xbv, s, stp, w, ea, eb, nx;
    logic [BW-1:0] ip1, ibp1, bm1;
    logic [NW-1:0] iap1, cnt;
    row_word_t     wd;

    state_nxt  = state_r;
    clr_nxt    = clr_r;
    row_nxt    = row_r;
    xa_nxt     = xa_r;
    xb_nxt     = xb_r;
    col_nxt    = col_r;
    os_nxt     = os_r;
    oc_nxt     = oc_r;
    on_nxt     = on_r;
    bx_nxt     = bx_r;
    bc_nxt     = bc_r;
    bn_nxt     = bn_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    best_nxt   = best_r;
    bestw_nxt  = bestw_r;
    x_nxt      = x_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    ia_nxt     = ia_r;
    ib_nxt     = ib_r;
    found_nxt  = found_r;
    merges_nxt = merges_r;
    ov_nxt     = 1'b0;
    orej_nxt   = orej_r;
    ochg_nxt   = ochg_r;
    ofirst_nxt = ofirst_r;
    olast_nxt  = olast_r;
    omrg_nxt   = omrg_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = row_r;
    wd         = '0;
    xl = '0; xf = '0; xbv = '0; s = '0; stp = '0; w = '0;
    ea = '0; eb = '0; nx = '0;
    ip1  = i_r + BW'(1);
    ibp1 = ib_r + BW'(1);
    bm1  = bn_r - BW'(1);
    iap1 = ia_r + NW'(1);
    cnt  = '0;

    unique case (state_r)
      ST_CLEAR: begin
        // one row per cycle: a single run of colour 0 at column 0
        wd.cnt    = NW'(1);
        mem_we    = 1'b1;
        mem_waddr = clr_r[RAW-1:0];
        clr_nxt   = clr_r + (RAW+1)'(1);
        if (clr_r == (RAW+1)'(ROW_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          xl = XW'(in_x_last);
          if (xl > XW'(ROW_WIDTH - 1)) begin
            xl = XW'(ROW_WIDTH - 1);
          end
          xf = XW'(in_x_first);
          if ((32'(in_row) >= ROW_COUNT) || (xf > xl)) begin
            ov_nxt     = 1'b1;
            orej_nxt   = 1'b1;
            ochg_nxt   = 1'b0;
            ofirst_nxt = '0;
            olast_nxt  = '0;
            omrg_nxt   = '0;
          end else begin
            xa_nxt = XW'((xf / X_GRID) * X_GRID);
            xbv    = XW'(((xl + XW'(X_GRID)) / X_GRID) * X_GRID);
            if (xbv > WLIM) begin
              xbv = WLIM;
            end
            xb_nxt    = xbv;
            row_nxt   = in_row[RAW-1:0];
            col_nxt   = in_colour;
            mem_re    = 1'b1;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cnt = mem_rdata.cnt;
        if (cnt < NW'(1)) begin
          cnt = NW'(1);
        end
        if (cnt > NW'(MAX_RUNS)) begin
          cnt = NW'(MAX_RUNS);
        end
        on_nxt = cnt;
        for (int k = 0; k < MAX_RUNS; k++) begin
          os_nxt[k] = XW'(mem_rdata.st[k]);
          oc_nxt[k] = mem_rdata.co[k];
        end
        bn_nxt     = '0;
        i_nxt      = '0;
        merges_nxt = '0;
        state_nxt  = ST_LEFT;
      end
      ST_LEFT: begin
        // runs left of the span, then the span itself
        if ((i_r < BW'(on_r)) && (os_r[i_r[MW-1:0]] < xa_r)) begin
          bx_nxt[bn_r] = os_r[i_r[MW-1:0]];
          bc_nxt[bn_r] = oc_r[i_r[MW-1:0]];
          bn_nxt       = bn_r + BW'(1);
          i_nxt        = ip1;
        end else begin
          bx_nxt[bn_r] = xa_r;
          bc_nxt[bn_r] = col_r;
          bn_nxt       = bn_r + BW'(1);
          i_nxt        = '0;
          state_nxt    = ST_RIGHT;
        end
      end
      ST_RIGHT: begin
        // clipped remainder of the old runs right of the span
        if (i_r < BW'(on_r)) begin
          s   = os_r[i_r[MW-1:0]];
          stp = (ip1 < BW'(on_r)) ? os_r[ip1[MW-1:0]] : WLIM;
          i_nxt = ip1;
          if (stp > xb_r) begin
            if (s < xb_r) begin
              s = xb_r;
            end
            if (s >= WLIM) begin
              bx_nxt[0] = '0;
              j_nxt     = '0;
              i_nxt     = BW'(1);
              state_nxt = ST_MERGE;
            end else if (s == bx_r[bm1]) begin
              bc_nxt[bm1] = oc_r[i_r[MW-1:0]];
            end else begin
              bx_nxt[bn_r] = s;
              bc_nxt[bn_r] = oc_r[i_r[MW-1:0]];
              bn_nxt       = bn_r + BW'(1);
            end
          end
        end else begin
          bx_nxt[0] = '0;
          j_nxt     = '0;
          i_nxt     = BW'(1);
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        // fold equal-colour neighbours in place
        if (i_r < bn_r) begin
          if (bc_r[i_r] != bc_r[j_r]) begin
            bx_nxt[j_r + BW'(1)] = bx_r[i_r];
            bc_nxt[j_r + BW'(1)] = bc_r[i_r];
            j_nxt = j_r + BW'(1);
          end
          i_nxt = ip1;
        end else begin
          bn_nxt    = j_r + BW'(1);
          state_nxt = ST_CAP;
        end
      end
      ST_CAP: begin
        if (bn_r > BW'(MAX_RUNS)) begin
          i_nxt     = BW'(1);
          best_nxt  = BW'(1);
          bestw_nxt = '1;
          state_nxt = ST_SCAN;
        end else begin
          x_nxt     = '0;
          ia_nxt    = '0;
          ib_nxt    = '0;
          found_nxt = 1'b0;
          lo_nxt    = '0;
          hi_nxt    = '0;
          state_nxt = ST_DIFF;
        end
      end
      ST_SCAN: begin
        // narrowest run past run 0, first on ties
        if (i_r < bn_r) begin
          w = ((ip1 < bn_r) ? bx_r[ip1] : WLIM) - bx_r[i_r];
          if (w < bestw_r) begin
            bestw_nxt = w;
            best_nxt  = i_r;
          end
          i_nxt = ip1;
        end else begin
          state_nxt = ST_DEL;
        end
      end
      ST_DEL: begin
        for (int k = 0; k < BUF_RUNS - 1; k++) begin
          if (BW'(k) >= best_r) begin
            bx_nxt[k] = bx_r[k + 1];
            bc_nxt[k] = bc_r[k + 1];
          end
        end
        bn_nxt = bm1;
        if (merges_r != 4'hF) begin
          merges_nxt = merges_r + 4'd1;
        end
        state_nxt = ST_CAP;
      end
      ST_DIFF: begin
        // column walk over old and new run lists together
        ea = (iap1 < on_r) ? os_r[iap1[MW-1:0]] : WLIM;
        eb = (ibp1 < bn_r) ? bx_r[ibp1] : WLIM;
        nx = (ea < eb) ? ea : eb;
        if ((x_r >= WLIM) || (nx <= x_r)) begin
          if (found_r) begin
            state_nxt = ST_WRITE;
          end else begin
            ov_nxt     = 1'b1;
            orej_nxt   = 1'b0;
            ochg_nxt   = 1'b0;
            ofirst_nxt = '0;
            olast_nxt  = '0;
            omrg_nxt   = merges_r;
            state_nxt  = ST_IDLE;
          end
        end else begin
          if (oc_r[ia_r[MW-1:0]] != bc_r[ib_r]) begin
            if (!found_r) begin
              lo_nxt = x_r;
            end
            found_nxt = 1'b1;
            hi_nxt    = nx - XW'(1);
          end
          x_nxt = nx;
          if ((ea <= nx) && (iap1 < on_r)) begin
            ia_nxt = iap1;
          end
          if ((eb <= nx) && (ibp1 < bn_r)) begin
            ib_nxt = ibp1;
          end
        end
      end
      ST_WRITE: begin
        wd.cnt = NW'(bn_r);
        for (int k = 0; k < MAX_RUNS; k++) begin
          wd.st[k] = bx_r[k][SW-1:0];
          wd.co[k] = bc_r[k];
        end
        mem_we     = 1'b1;
        ov_nxt     = 1'b1;
        orej_nxt   = 1'b0;
        ochg_nxt   = 1'b1;
        ofirst_nxt = lo_r[8:0];
        olast_nxt  = hi_r[8:0];
        omrg_nxt   = merges_r;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    mem_wdata = wd;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = ov_r;
  assign out_rejected   = orej_r;
  assign out_changed    = ochg_r;
  assign out_diff_first = ofirst_r;
  assign out_diff_last  = olast_r;
  assign out_merges     = omrg_r;
endmodule
`default_nettype wire
